// ===== hw/rtl/erlp_pkg.sv =====
// shared types and constants of the embedded register line parser
`timescale 1ns / 1ps
`default_nettype none
package erlp_pkg;

  localparam int unsigned PositionBits = 12;
  localparam int unsigned LimitBits    = 12;
  localparam int unsigned CmpBits      = (PositionBits > LimitBits) ? PositionBits : LimitBits;

  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

  localparam logic [7:0] TagAddrHigh = 8'hAA;
  localparam logic [7:0] TagAddrLow  = 8'hA5;
  localparam logic [7:0] TagValue    = 8'h5A;
  localparam logic [7:0] StartOfLine = 8'h0A;

  // 1828 / 2 * 3 and 1500 / 2 * 3
  localparam logic [LimitBits-1:0] LimitRow0Reset = LimitBits'(1828 / 2 * 3);
  localparam logic [LimitBits-1:0] LimitRow1Reset = LimitBits'(1500 / 2 * 3);

  // configuration register indexes
  localparam logic RegLimitRow0 = 1'b0;
  localparam logic RegLimitRow1 = 1'b1;

  // result kinds
  localparam logic KindRegister = 1'b0;
  localparam logic KindBadStart = 1'b1;

  // position modulo three
  localparam logic [1:0] PhaseValue = 2'd0;
  localparam logic [1:0] PhaseTag   = 2'd1;
  localparam logic [1:0] PhasePad   = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [15:0] value;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/erlp_skid.sv =====
// output register with skid stage for decoded results
`timescale 1ns / 1ps
`default_nettype none
module erlp_skid (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push_i,
  input  erlp_pkg::result_t        push_data_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output erlp_pkg::result_t        out_data_o
);

  logic               out_valid_q, skid_valid_q;
  erlp_pkg::result_t  out_q, skid_q;
  logic               pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no push can arrive while the skid entry is held
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (!out_valid_q || pop) begin
      if (push_i) out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/embedded_register_line_parser.sv =====
// top level of the embedded register line parser
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte of a sensor's embedded register line per transaction and
// decodes tag / padding / value triplets into 16-bit register address and
// value pairs. A byte flagged by line_start must be 0x0a, otherwise a bad
// start-of-line result is returned and the rest of the row is ignored.
// Throughput is one byte per clock while input stall is low: the whole
// decode of a byte is a single pass of logic between the parser state
// registers and the result register, and the position modulo three is
// carried in its own small counter so no divider sits in the path. A
// two-entry output (result register plus skid entry) lets the block keep
// taking bytes while a result waits; input stall rises only when both
// entries are full. The per-row tag limits must be written through the
// configuration port only while the block is idle; this is not enforced.
module embedded_register_line_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  // byte input
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         line_start_i,
  input  wire         row_number_i,
  // result output
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        result_kind_o,
  output logic [15:0] reg_address_o,
  output logic [15:0] reg_value_o,
  // configuration
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [erlp_pkg::LimitBits-1:0] cfg_data_i
);

  // tag position limits
  logic [erlp_pkg::LimitBits-1:0] limit_row0_q, limit_row1_q;

  // parser state
  logic [erlp_pkg::PositionBits-1:0] pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;        // pos_q modulo three
  logic [7:0]  tag_q, tag_d;
  logic        tag_in_range_q, tag_in_range_d;
  logic [15:0] addr_q, addr_d;
  logic        value_phase_q, value_phase_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic        skipped_q, skipped_d;

  logic               accept;
  logic               res_valid;
  erlp_pkg::result_t  res;
  logic               skid_full;
  erlp_pkg::result_t  out_data;
  logic [erlp_pkg::LimitBits-1:0] limit;

  assign accept = in_valid_i & ~in_stall_o;
  assign limit  = row_number_i ? limit_row1_q : limit_row0_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_row0_q <= erlp_pkg::LimitRow0Reset;
      limit_row1_q <= erlp_pkg::LimitRow1Reset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        erlp_pkg::RegLimitRow0: limit_row0_q <= cfg_data_i;
        erlp_pkg::RegLimitRow1: limit_row1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // single-pass byte decode
  always_comb begin
    pos_d          = pos_q;
    phase_d        = phase_q;
    tag_d          = tag_q;
    tag_in_range_d = tag_in_range_q;
    addr_d         = addr_q;
    value_phase_d  = value_phase_q;
    high_byte_d    = high_byte_q;
    skipped_d      = skipped_q;
    res_valid      = 1'b0;
    res.kind       = erlp_pkg::KindRegister;
    res.address    = addr_q;
    res.value      = {high_byte_q, data_byte_i};

    if (line_start_i) begin
      // restart the row at position 0, next byte is position 1
      skipped_d      = 1'b0;
      tag_in_range_d = 1'b0;
      tag_d          = 8'h00;
      addr_d         = 16'h0000;
      value_phase_d  = 1'b0;
      pos_d          = erlp_pkg::PositionBits'(1);
      phase_d        = erlp_pkg::PhaseTag;
      if (data_byte_i != erlp_pkg::StartOfLine) begin
        skipped_d   = 1'b1;
        res_valid   = 1'b1;
        res.kind    = erlp_pkg::KindBadStart;
        res.address = 16'h0000;
        res.value   = 16'h0000;
      end
    end else if (!skipped_q) begin
      if (phase_q == erlp_pkg::PhaseTag) begin
        tag_d          = data_byte_i;
        tag_in_range_d = (erlp_pkg::CmpBits'(pos_q) <= erlp_pkg::CmpBits'(limit));
      end else if (phase_q == erlp_pkg::PhaseValue && pos_q != '0 && tag_in_range_q) begin
        tag_in_range_d = 1'b0;
        priority if (tag_q == erlp_pkg::TagAddrHigh) begin
          addr_d = {data_byte_i, 8'h00};
        end else if (tag_q == erlp_pkg::TagAddrLow) begin
          addr_d = (addr_q | {8'h00, data_byte_i}) - 16'd2;
        end else if (tag_q == erlp_pkg::TagValue) begin
          if (!value_phase_q) begin
            // first of a pair: bump address, hold the high value byte
            addr_d        = addr_q + 16'd2;
            high_byte_d   = data_byte_i;
            value_phase_d = 1'b1;
          end else begin
            value_phase_d = 1'b0;
            res_valid     = 1'b1;
          end
        end else begin
          // unknown tag, nothing to do
        end
      end

      // position counter saturates at the end of the row
      if (pos_q == erlp_pkg::PosMax) begin
        skipped_d = 1'b1;
      end else begin
        pos_d   = pos_q + erlp_pkg::PositionBits'(1);
        phase_d = (phase_q == erlp_pkg::PhasePad) ? erlp_pkg::PhaseValue
                                                  : phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      phase_q        <= erlp_pkg::PhaseValue;
      tag_q          <= 8'h00;
      tag_in_range_q <= 1'b0;
      addr_q         <= 16'h0000;
      value_phase_q  <= 1'b0;
      high_byte_q    <= 8'h00;
      skipped_q      <= 1'b0;
    end else if (accept) begin
      pos_q          <= pos_d;
      phase_q        <= phase_d;
      tag_q          <= tag_d;
      tag_in_range_q <= tag_in_range_d;
      addr_q         <= addr_d;
      value_phase_q  <= value_phase_d;
      high_byte_q    <= high_byte_d;
      skipped_q      <= skipped_d;
    end
  end

  erlp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & res_valid),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  // stall only when both output entries hold results
  assign in_stall_o    = skid_full;
  assign result_kind_o = out_data.kind;
  assign reg_address_o = out_data.address;
  assign reg_value_o   = out_data.value;

  // skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> out_valid_o)
    else $error("skid entry valid without output result");

  // a bad start-of-line byte always yields a pending result
  a_bad_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_start_i && data_byte_i != erlp_pkg::StartOfLine)
      |=> out_valid_o)
    else $error("bad start-of-line byte produced no result");

  // error results carry zero address and value
  a_bad_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == erlp_pkg::KindBadStart)
      |-> (reg_address_o == 16'h0000 && reg_value_o == 16'h0000))
    else $error("error result with nonzero payload");

  // modulo-three counter stays in range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("position phase out of range");

endmodule
`default_nettype wire
